@@ hw/rtl/bsta_pkg.sv @@
// shared types and codes for the bounded set table algebra unit
package bsta_pkg;

  localparam int ElemW = 32;
  localparam int SizeW = 6;

  typedef enum logic [2:0] {
    OP_INS_A  = 3'd0,
    OP_INS_B  = 3'd1,
    OP_REM_A  = 3'd2,
    OP_SRCH_A = 3'd3,
    OP_UNION  = 3'd4,
    OP_INTER  = 3'd5,
    OP_DIFF   = 3'd6,
    OP_SUBSET = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // control broadcast from sequencer to every cell
  typedef struct packed {
    logic             load;    // load own slot from the insert value
    logic             shift;   // take the value of the right neighbour
    logic [SizeW-1:0] ld_idx;  // slot written on load
    logic [SizeW-1:0] sh_from; // cells at or above this index shift
    logic             rot;     // rotate the whole ring by one place
  } cell_ctl_t;

endpackage

@@ hw/rtl/bsta_if.sv @@
// valid/ready channel carrying one word
interface bsta_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/bsta_cell.sv @@
// one storage cell of a set ring: holds one element, passes it on
module bsta_cell
  import bsta_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [ElemW-1:0] load_val,
  input  logic [ElemW-1:0] nbr_val,
  output logic [ElemW-1:0] val
);

  logic [ElemW-1:0] val_r;
  logic [ElemW-1:0] val_nxt;

  // load, compaction shift or ring rotation
  always_comb begin
    val_nxt = val_r;
    if (ctl.load && ctl.ld_idx == SizeW'(IDX)) begin
      val_nxt = load_val;
    end else if (ctl.rot) begin
      val_nxt = nbr_val;
    end else if (ctl.shift && SizeW'(IDX) >= ctl.sh_from) begin
      val_nxt = nbr_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

@@ hw/rtl/bsta_ring.sv @@
// a row of cells forming one set; cell 0 is the head
module bsta_ring
  import bsta_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [ElemW-1:0] load_val,
  output logic [ElemW-1:0] head
);

  logic [ElemW-1:0] v [CAPACITY];

  // each cell takes its right neighbour; the last cell takes the head
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    bsta_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_val (load_val),
      .nbr_val  (v[(g + 1) % CAPACITY]),
      .val      (v[g])
    );
  end

  assign head = v[0];

endmodule

@@ hw/rtl/bounded_set_table_algebra_unit.sv @@
// top level: bounded set table algebra unit with two cell rings
//
// channel | dir | payload
// in_     | in  | operation, element
// out_    | out | status, flag, size_a, result_element, empty_result, last
//
// inserts load one cell directly; remove and search walk ring A once by
// rotation, and remove then shifts the cells from the match on.
// subset, intersection and difference rotate the outer ring once and, per
// outer entry, the inner ring once; union adds a pass over A first.
// a stalled result holds the sequencer; a new word is taken while the last
// result of the previous one still waits in the output register.
// reset clears both counts; ring contents are undefined until written.
module bounded_set_table_algebra_unit
  import bsta_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  bsta_if.sink   in_ch,
  bsta_if.source out_ch
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_INNER = 6'b000100,
    S_EMIT  = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  localparam int OutW = 2 + 1 + SizeW + ElemW + 1 + 1;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [ElemW-1:0] key_r, key_nxt;
  logic [SizeW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [SizeW-1:0] oi_r, oi_nxt;    // outer rotation count
  logic [SizeW-1:0] ii_r, ii_nxt;    // inner rotation count
  logic             hit_r, hit_nxt;  // match found in current inner pass
  logic             any_r, any_nxt;  // an element is held back for the last mark
  logic             sub_r, sub_nxt;
  logic             phase_b_r, phase_b_nxt; // union second half
  logic [SizeW-1:0] pos_r, pos_nxt;
  logic             ov_r, ov_nxt;
  logic [OutW-1:0]  ob_r, ob_nxt;
  logic             ob_last_r;
  logic             pend_r, pend_nxt;     // newly found element queued
  logic [ElemW-1:0] pend_v_r, pend_v_nxt;
  logic [ElemW-1:0] held_v_r, held_v_nxt; // element waiting for its successor
  cell_ctl_t        ctl_a, ctl_b;
  logic [ElemW-1:0] head_a, head_b;

  bsta_ring #(.CAPACITY(CAPACITY)) u_ring_a (
    .clk(clk), .ctl(ctl_a), .load_val(key_r), .head(head_a));
  bsta_ring #(.CAPACITY(CAPACITY)) u_ring_b (
    .clk(clk), .ctl(ctl_b), .load_val(key_r), .head(head_b));

  localparam logic [SizeW-1:0] Cap = SizeW'(CAPACITY);

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = ob_r;

  wire out_free = !ov_r || out_ch.ready;
  wire [SizeW-1:0] cnt_a_m1 = cnt_a_r - SizeW'(1);

  function automatic logic [OutW-1:0] pack(status_t s, logic f, logic [SizeW-1:0] sz,
                                           logic [ElemW-1:0] e, logic em, logic l);
    pack = {s, f, sz, e, em, l};
  endfunction

  // sequencer
  always_comb begin
    logic is_alg;
    logic outer_b;
    logic [SizeW-1:0] outer_n, inner_n;
    logic [ElemW-1:0] ohead, ihead;
    state_nxt = state_r; op_nxt = op_r; key_nxt = key_r;
    cnt_a_nxt = cnt_a_r; cnt_b_nxt = cnt_b_r; oi_nxt = oi_r; ii_nxt = ii_r;
    hit_nxt = hit_r; any_nxt = any_r; sub_nxt = sub_r; phase_b_nxt = phase_b_r;
    pos_nxt = pos_r; ov_nxt = ov_r; ob_nxt = ob_r;
    pend_nxt = pend_r; pend_v_nxt = pend_v_r; held_v_nxt = held_v_r;
    ctl_a = '0; ctl_b = '0;
    is_alg = (op_r == OP_UNION) || (op_r == OP_INTER) || (op_r == OP_DIFF);
    // union phase b and subset rotate B outer, A inner; others A outer, B inner
    outer_b = (op_r == OP_SUBSET) || (op_r == OP_UNION && phase_b_r);
    outer_n = outer_b ? cnt_b_r : cnt_a_r;
    inner_n = (op_r == OP_UNION || op_r == OP_SUBSET) ? cnt_a_r : cnt_b_r;
    ohead = outer_b ? head_b : head_a;
    ihead = outer_b ? head_a : head_b;

    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          op_nxt = op_t'(in_ch.data[ElemW +: 3]);
          key_nxt = in_ch.data[ElemW-1:0];
          oi_nxt = '0; ii_nxt = '0; hit_nxt = 1'b0; any_nxt = 1'b0;
          sub_nxt = 1'b1; phase_b_nxt = 1'b0; pend_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (op_r)
          OP_INS_A, OP_INS_B: begin
            if (out_free) begin
              if ((op_r == OP_INS_A ? cnt_a_r : cnt_b_r) >= Cap) begin
                ob_nxt = pack(ST_FULL, 1'b0, cnt_a_r, '0, 1'b0, 1'b1);
              end else if (op_r == OP_INS_A) begin
                ctl_a.load = 1'b1; ctl_a.ld_idx = cnt_a_r;
                cnt_a_nxt = cnt_a_r + SizeW'(1);
                ob_nxt = pack(ST_OK, 1'b0, cnt_a_r + SizeW'(1), '0, 1'b0, 1'b1);
              end else begin
                ctl_b.load = 1'b1; ctl_b.ld_idx = cnt_b_r;
                cnt_b_nxt = cnt_b_r + SizeW'(1);
                ob_nxt = pack(ST_OK, 1'b0, cnt_a_r, '0, 1'b0, 1'b1);
              end
              ov_nxt = 1'b1; state_nxt = S_IDLE;
            end
          end
          OP_REM_A, OP_SRCH_A: begin
            // rotate A once fully, note first match position
            if (oi_r == Cap) begin
              if (op_r == OP_SRCH_A) begin
                state_nxt = S_DONE;
              end else if (out_free) begin
                if (cnt_a_r == '0) begin
                  ob_nxt = pack(ST_EMPTY, 1'b0, cnt_a_r, '0, 1'b0, 1'b1);
                  state_nxt = S_DONE;
                end else if (!hit_r) begin
                  ob_nxt = pack(ST_NOT_FOUND, 1'b0, cnt_a_r, '0, 1'b0, 1'b1);
                  state_nxt = S_DONE;
                end else begin
                  state_nxt = S_SHIFT;
                end
              end
            end else begin
              if (!hit_r && oi_r < cnt_a_r && head_a == key_r) begin
                hit_nxt = 1'b1; pos_nxt = oi_r;
              end
              ctl_a.rot = 1'b1;
              oi_nxt = oi_r + SizeW'(1);
            end
          end
          default: begin
            // pairwise: outer ring head held while inner ring rotates
            if (pend_r) begin
              // the held element goes out once a later one is known
              if (!any_r) begin
                held_v_nxt = pend_v_r; any_nxt = 1'b1; pend_nxt = 1'b0;
              end else if (out_free) begin
                ob_nxt = pack(ST_OK, 1'b0, cnt_a_r, held_v_r, 1'b0, 1'b0);
                ov_nxt = 1'b1; held_v_nxt = pend_v_r; pend_nxt = 1'b0;
              end
            end else if (oi_r == Cap) begin
              if (op_r == OP_UNION && !phase_b_r) begin
                phase_b_nxt = 1'b1; oi_nxt = '0;
              end else begin
                state_nxt = S_DONE;
              end
            end else if (op_r == OP_UNION && !phase_b_r) begin
              if (oi_r < cnt_a_r) begin
                pend_nxt = 1'b1; pend_v_nxt = head_a;
              end
              ctl_a.rot = 1'b1; oi_nxt = oi_r + SizeW'(1);
            end else if (oi_r >= outer_n) begin
              if (outer_b) ctl_b.rot = 1'b1; else ctl_a.rot = 1'b1;
              oi_nxt = oi_r + SizeW'(1);
            end else begin
              key_nxt = ohead; ii_nxt = '0; hit_nxt = 1'b0;
              state_nxt = S_INNER;
            end
          end
        endcase
      end
      S_INNER: begin
        if (ii_r == Cap) begin
          // decision for this outer entry
          if (op_r == OP_SUBSET) begin
            if (!hit_r) sub_nxt = 1'b0;
          end else if ((op_r == OP_INTER) ? hit_r : !hit_r) begin
            pend_nxt = 1'b1; pend_v_nxt = key_r;
          end
          if (outer_b) ctl_b.rot = 1'b1; else ctl_a.rot = 1'b1;
          oi_nxt = oi_r + SizeW'(1);
          state_nxt = S_SCAN;
        end else begin
          if (ii_r < inner_n && ihead == key_r) hit_nxt = 1'b1;
          if (outer_b) ctl_a.rot = 1'b1; else ctl_b.rot = 1'b1;
          ii_nxt = ii_r + SizeW'(1);
        end
      end
      S_SHIFT: begin
        if (out_free) begin
          ctl_a.shift = 1'b1; ctl_a.sh_from = pos_r;
          cnt_a_nxt = cnt_a_m1;
          ob_nxt = pack(ST_OK, 1'b0, cnt_a_m1, '0, 1'b0, 1'b1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (op_r == OP_SRCH_A) begin
            ob_nxt = pack(ST_OK, hit_r, cnt_a_r, '0, 1'b0, 1'b1);
          end else if (op_r == OP_SUBSET) begin
            ob_nxt = pack(ST_OK, sub_r, cnt_a_r, '0, 1'b0, 1'b1);
          end else if (is_alg) begin
            ob_nxt = any_r ? pack(ST_OK, 1'b0, cnt_a_r, held_v_r, 1'b0, 1'b1)
                           : pack(ST_OK, 1'b0, cnt_a_r, '0, 1'b1, 1'b1);
          end
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_a_r <= '0; cnt_b_r <= '0; ov_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_a_r <= cnt_a_nxt; cnt_b_r <= cnt_b_nxt;
      ov_r <= ov_nxt; pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; key_r <= key_nxt; oi_r <= oi_nxt; ii_r <= ii_nxt;
    hit_r <= hit_nxt; any_r <= any_nxt; sub_r <= sub_nxt; phase_b_r <= phase_b_nxt;
    pos_r <= pos_nxt; ob_r <= ob_nxt; pend_v_r <= pend_v_nxt;
    held_v_r <= held_v_nxt;
  end

  assign ob_last_r = ob_r[0];

  // checks
  a_cnt_a_cap : assert property (@(posedge clk) disable iff (!rst_n) cnt_a_r <= Cap)
    else $error("count of A above capacity");
  a_cnt_b_cap : assert property (@(posedge clk) disable iff (!rst_n) cnt_b_r <= Cap)
    else $error("count of B above capacity");
  a_idle_last : assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && state_r == S_IDLE) |-> ob_last_r)
    else $error("block idle while a non-final word waits");

endmodule

@@ test/tb.sv @@
// testbench for the bounded set table algebra unit: directed and random words
`timescale 1ns / 100ps

module tb;
  import bsta_pkg::*;

  localparam int Cap = 32;
  localparam int InW = 3 + ElemW;
  localparam int OutW = 2 + 1 + SizeW + ElemW + 1 + 1;

  typedef struct {
    status_t          status;
    logic             flag;
    logic [SizeW-1:0] size_a;
    logic [ElemW-1:0] elem;
    logic             empty;
    logic             last;
  } answer_t;

  logic clk;
  logic rst_n;

  bsta_if #(.W(InW)) in_ch ();
  bsta_if #(.W(OutW)) out_ch ();

  bounded_set_table_algebra_unit #(.CAPACITY(Cap)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // own copy of both tables
  logic [ElemW-1:0] tab_a[Cap];
  logic [ElemW-1:0] tab_b[Cap];
  int               cnt_a;
  int               cnt_b;

  answer_t          answers[$];
  int               n_bad;
  int               send_gap_pct;
  int               stall_pct;
  logic [ElemW-1:0] pool[8];

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit holds(ref logic [ElemW-1:0] tab[Cap], input int n,
                               input logic [ElemW-1:0] v);
    for (int i = 0; i < n; i++) if (tab[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void push_answer(status_t st, logic fl, logic [ElemW-1:0] el,
                                      logic emp, logic lst);
    answer_t r;
    r.status = st;
    r.flag   = fl;
    r.size_a = cnt_a[SizeW-1:0];
    r.elem   = el;
    r.empty  = emp;
    r.last   = lst;
    answers.push_back(r);
  endfunction

  // work out the words one operation produces and update the tables
  function automatic void apply_op(op_t op, logic [ElemW-1:0] v);
    int      base;
    int      pos;
    logic    sub;
    base = answers.size();
    case (op)
      OP_INS_A: begin
        if (cnt_a >= Cap) push_answer(ST_FULL, 0, 0, 0, 1);
        else begin
          tab_a[cnt_a] = v;
          cnt_a++;
          push_answer(ST_OK, 0, 0, 0, 1);
        end
      end
      OP_INS_B: begin
        if (cnt_b >= Cap) push_answer(ST_FULL, 0, 0, 0, 1);
        else begin
          tab_b[cnt_b] = v;
          cnt_b++;
          push_answer(ST_OK, 0, 0, 0, 1);
        end
      end
      OP_REM_A: begin
        pos = -1;
        for (int i = 0; i < cnt_a; i++) if (pos < 0 && tab_a[i] == v) pos = i;
        if (cnt_a == 0) push_answer(ST_EMPTY, 0, 0, 0, 1);
        else if (pos < 0) push_answer(ST_NOT_FOUND, 0, 0, 0, 1);
        else begin
          for (int j = pos; j + 1 < cnt_a; j++) tab_a[j] = tab_a[j+1];
          cnt_a--;
          push_answer(ST_OK, 0, 0, 0, 1);
        end
      end
      OP_SRCH_A: push_answer(ST_OK, holds(tab_a, cnt_a, v), 0, 0, 1);
      OP_SUBSET: begin
        sub = 1'b1;
        for (int i = 0; i < cnt_b; i++) if (!holds(tab_a, cnt_a, tab_b[i])) sub = 1'b0;
        push_answer(ST_OK, sub, 0, 0, 1);
      end
      default: begin
        if (op == OP_UNION) begin
          for (int i = 0; i < cnt_a; i++) push_answer(ST_OK, 0, tab_a[i], 0, 0);
          for (int i = 0; i < cnt_b; i++)
            if (!holds(tab_a, cnt_a, tab_b[i])) push_answer(ST_OK, 0, tab_b[i], 0, 0);
        end else begin
          for (int i = 0; i < cnt_a; i++)
            if (holds(tab_b, cnt_b, tab_a[i]) == (op == OP_INTER))
              push_answer(ST_OK, 0, tab_a[i], 0, 0);
        end
        if (answers.size() == base) push_answer(ST_OK, 0, 0, 1, 1);
        else answers[answers.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  // result side: random back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each accepted result word with the oldest expected one
  always @(posedge clk) begin
    answer_t          e;
    logic [1:0]       g_st;
    logic             g_fl;
    logic [SizeW-1:0] g_sz;
    logic [ElemW-1:0] g_el;
    logic             g_em;
    logic             g_ls;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      {g_st, g_fl, g_sz, g_el, g_em, g_ls} = out_ch.data;
      if (answers.size() == 0) begin
        n_bad++;
        $display("%0t: unexpected word %h", $time, out_ch.data);
      end else begin
        e = answers.pop_front();
        if (g_st !== e.status || g_fl !== e.flag || g_sz !== e.size_a ||
            g_el !== e.elem || g_em !== e.empty || g_ls !== e.last) begin
          n_bad++;
          $display("%0t: expected st %0d fl %b sz %0d el %h em %b ls %b", $time,
                   e.status, e.flag, e.size_a, e.elem, e.empty, e.last);
          $display("%0t: actual   st %0d fl %b sz %0d el %h em %b ls %b", $time,
                   g_st, g_fl, g_sz, g_el, g_em, g_ls);
        end
      end
    end
  end

  // send one input word; valid stays high afterwards until a send gap or go_quiet
  task automatic send_word(op_t op, logic [ElemW-1:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {op, v};
    do @(posedge clk); while (!in_ch.ready);
    apply_op(op, v);
  endtask

  task automatic go_quiet();
    in_ch.valid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [ElemW-1:0] pick_value();
    return ($urandom_range(3) == 0) ? $urandom : pool[$urandom_range(7)];
  endfunction

  // empty tables, extreme values, duplicates and the first-match remove
  task automatic test_directed();
    send_word(OP_SRCH_A, 0);
    send_word(OP_REM_A, 0);
    send_word(OP_SUBSET, 0);
    send_word(OP_UNION, 0);
    send_word(OP_INTER, 0);
    send_word(OP_DIFF, 0);
    send_word(OP_INS_A, 32'h8000_0000);
    send_word(OP_SUBSET, 0);
    send_word(OP_INS_A, 32'h7fff_ffff);
    send_word(OP_INS_A, 32'h0000_0000);
    send_word(OP_INS_A, 32'h7fff_ffff);
    send_word(OP_INS_B, 32'hffff_ffff);
    send_word(OP_INS_B, 32'h7fff_ffff);
    send_word(OP_SUBSET, 0);
    send_word(OP_UNION, 0);
    send_word(OP_INTER, 0);
    send_word(OP_DIFF, 0);
    send_word(OP_SRCH_A, 32'h7fff_ffff);
    send_word(OP_SRCH_A, 32'hffff_ffff);
    send_word(OP_REM_A, 32'h1234_5678);
    send_word(OP_REM_A, 32'h7fff_ffff);
    send_word(OP_REM_A, 32'h8000_0000);
    send_word(OP_UNION, 0);
    go_quiet();
  endtask

  // fill both tables, hit the full status, then empty A again
  task automatic test_capacity();
    while (cnt_a < Cap) send_word(OP_INS_A, pick_value());
    send_word(OP_INS_A, pick_value());
    while (cnt_b < Cap) send_word(OP_INS_B, pick_value());
    send_word(OP_INS_B, pick_value());
    send_word(OP_UNION, 0);
    send_word(OP_INTER, 0);
    send_word(OP_DIFF, 0);
    send_word(OP_SUBSET, 0);
    while (cnt_a > 0) send_word(OP_REM_A, tab_a[$urandom_range(cnt_a - 1)]);
    send_word(OP_REM_A, pick_value());
    send_word(OP_SUBSET, 0);
    send_word(OP_DIFF, 0);
    go_quiet();
  endtask

  // random mix with values drawn mostly from a small pool so matches occur
  task automatic test_random(int n);
    int  r;
    op_t op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 30) op = OP_INS_A;
      else if (r < 38) op = OP_INS_B;
      else if (r < 58) op = OP_REM_A;
      else if (r < 70) op = OP_SRCH_A;
      else if (r < 77) op = OP_UNION;
      else if (r < 84) op = OP_INTER;
      else if (r < 91) op = OP_DIFF;
      else op = OP_SUBSET;
      if (op == OP_REM_A && cnt_a > 0 && $urandom_range(1))
        send_word(op, tab_a[$urandom_range(cnt_a - 1)]);
      else send_word(op, pick_value());
    end
    go_quiet();
  endtask

  initial begin
    n_bad        = 0;
    cnt_a        = 0;
    cnt_b        = 0;
    send_gap_pct = 7;
    stall_pct    = 64;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    rst_n        = 1'b0;
    pool = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             $urandom, $urandom, $urandom};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random(30);
    send_gap_pct = 64;
    stall_pct    = 7;
    test_random(30);
    send_gap_pct = 0;
    stall_pct    = 0;
    test_random(30);
    if (n_bad == 0) $display("bounded_set_table_algebra_unit: match");
    else $display("bounded_set_table_algebra_unit: mismatch");
    $finish;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("bounded_set_table_algebra_unit: mismatch");
    $finish;
  end

endmodule
